@@ src/assert_macros.svh @@
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, masked while reset is high
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/fbn_pkg.sv @@
package fbn_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W = 24;
   localparam int AXIS_W = 18;
   localparam int PROD_W = AXIS_W + IN_W;
   localparam int VEC_W = PROD_W + 1;
   localparam int MAG_W = VEC_W;
   localparam int PRE_W = 30;
   localparam int SQ_W = 2 * PRE_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int SQ_STEPS = SUM_W / 2;
   localparam int ROOT_W = SQ_STEPS;
   localparam int REM_W = ROOT_W + 3;
   localparam int Q_W = FRAC_BITS + 1;
   localparam int DIV_W = ROOT_W + FRAC_BITS + 1;
   localparam int SH_W = $clog2(MAG_W - PRE_W + 1);
   localparam int AXIS_ONE = 1 << FRAC_BITS;
   localparam int AXIS_FIELD_MAX = (1 << (AXIS_W - 1)) - 1;
   localparam int AXIS_MAX = (AXIS_ONE < AXIS_FIELD_MAX) ? AXIS_ONE : AXIS_FIELD_MAX;

   // unit latency: abs, max, shift search, shift, square, sum, root, setup, quotient, sign
   localparam int UNIT_LAT = 6 + SQ_STEPS + 1 + Q_W + 1;
   localparam int DEPTH = 3 * UNIT_LAT + 4;
   localparam int U1_TAP = UNIT_LAT - 1;
   localparam int U2_TAP = 2 * UNIT_LAT + 1;
   localparam int SIDE_TAP = U2_TAP + 1;
   localparam int LAST_TAP = DEPTH - 1;

   localparam int REQ_W = 9 * IN_W;
   localparam int RSP_BITS = 6 * AXIS_W + 6 * IN_W;
   localparam int RSP_W = ((RSP_BITS + 7) / 8) * 8;

   typedef logic signed [IN_W-1:0] in_type;
   typedef logic signed [AXIS_W-1:0] axis_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [VEC_W-1:0] vec_type;

endpackage

@@ src/fbn_unit_vec.sv @@
module fbn_unit_vec (
   input  logic              clock,
   input  logic              enable,
   input  fbn_pkg::vec_type  vec [3],
   output fbn_pkg::axis_type axis [3]
);

   typedef logic [fbn_pkg::MAG_W-1:0] mag_type;
   typedef logic [fbn_pkg::PRE_W-1:0] pre_type;

   typedef struct packed {
      logic [fbn_pkg::SUM_W-1:0]  s;
      logic [fbn_pkg::REM_W-1:0]  rem;
      logic [fbn_pkg::ROOT_W-1:0] root;
      logic [2:0][fbn_pkg::PRE_W-1:0] mag;
      logic [2:0] neg;
      logic       zero;
   } sq_type;

   typedef struct packed {
      logic [2:0][fbn_pkg::DIV_W-1:0] rem;
      logic [2:0][fbn_pkg::Q_W-1:0]   q;
      logic [fbn_pkg::ROOT_W-1:0]     len;
      logic [2:0] neg;
      logic       zero;
   } dv_type;

   mag_type a_mag_ff [3];
   logic [2:0] a_neg_ff;
   mag_type b_mag_ff [3];
   logic [2:0] b_neg_ff;
   mag_type b_max_ff;
   mag_type c_mag_ff [3];
   logic [2:0] c_neg_ff;
   logic [fbn_pkg::SH_W-1:0] c_sh_ff;
   logic c_zero_ff;
   pre_type d_mag_ff [3];
   logic [2:0] d_neg_ff;
   logic d_zero_ff;
   logic [fbn_pkg::SQ_W-1:0] e_sq_ff [3];
   pre_type e_mag_ff [3];
   logic [2:0] e_neg_ff;
   logic e_zero_ff;
   logic [fbn_pkg::SUM_W-1:0] f_sum_ff;
   pre_type f_mag_ff [3];
   logic [2:0] f_neg_ff;
   logic f_zero_ff;
   sq_type sq_ff [fbn_pkg::SQ_STEPS];
   sq_type sq_in [fbn_pkg::SQ_STEPS];
   dv_type g_ff;
   dv_type g_in;
   dv_type dv_ff [fbn_pkg::Q_W];
   dv_type dv_in [fbn_pkg::Q_W];
   fbn_pkg::axis_type h_ff [3];
   fbn_pkg::axis_type h_in [3];
   mag_type a_mag_in [3];
   mag_type b_max_in;
   logic [fbn_pkg::SH_W-1:0] c_sh_in;

   // magnitude and sign
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a_mag_in[k] = vec[k][fbn_pkg::VEC_W-1] ? (~vec[k] + 1'b1) : vec[k];
      end
   end

   always_comb begin
      b_max_in = (a_mag_ff[0] > a_mag_ff[1]) ? a_mag_ff[0] : a_mag_ff[1];
      if (a_mag_ff[2] > b_max_in) begin
         b_max_in = a_mag_ff[2];
      end
   end

   // smallest right shift that brings the largest magnitude below the prescale limit
   always_comb begin
      c_sh_in = '0;
      for (int i = fbn_pkg::PRE_W; i < fbn_pkg::MAG_W; i++) begin
         if (b_max_ff[i]) begin
            c_sh_in = fbn_pkg::SH_W'(i - fbn_pkg::PRE_W + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            a_mag_ff[k] <= a_mag_in[k];
            a_neg_ff[k] <= vec[k][fbn_pkg::VEC_W-1];
            b_mag_ff[k] <= a_mag_ff[k];
            c_mag_ff[k] <= b_mag_ff[k];
            d_mag_ff[k] <= fbn_pkg::PRE_W'(c_mag_ff[k] >> c_sh_ff);
            e_sq_ff[k] <= fbn_pkg::SQ_W'(d_mag_ff[k]) * fbn_pkg::SQ_W'(d_mag_ff[k]);
            e_mag_ff[k] <= d_mag_ff[k];
            f_mag_ff[k] <= e_mag_ff[k];
         end
         b_neg_ff <= a_neg_ff;
         b_max_ff <= b_max_in;
         c_neg_ff <= b_neg_ff;
         c_sh_ff <= c_sh_in;
         c_zero_ff <= (b_max_ff == '0);
         d_neg_ff <= c_neg_ff;
         d_zero_ff <= c_zero_ff;
         e_neg_ff <= d_neg_ff;
         e_zero_ff <= d_zero_ff;
         f_sum_ff <= fbn_pkg::SUM_W'(e_sq_ff[0]) + fbn_pkg::SUM_W'(e_sq_ff[1])
                   + fbn_pkg::SUM_W'(e_sq_ff[2]);
         f_neg_ff <= e_neg_ff;
         f_zero_ff <= e_zero_ff;
      end
   end

   // integer square root, one result bit per stage
   always_comb begin
      sq_type prev;
      logic [fbn_pkg::REM_W-1:0] rem_t;
      logic [fbn_pkg::REM_W-1:0] trial;
      for (int j = 0; j < fbn_pkg::SQ_STEPS; j++) begin
         if (j == 0) begin
            prev.s = f_sum_ff;
            prev.rem = '0;
            prev.root = '0;
            for (int k = 0; k < 3; k++) begin
               prev.mag[k] = f_mag_ff[k];
            end
            prev.neg = f_neg_ff;
            prev.zero = f_zero_ff;
         end else begin
            prev = sq_ff[j-1];
         end
         rem_t = {prev.rem[fbn_pkg::REM_W-3:0], prev.s[fbn_pkg::SUM_W-1 -: 2]};
         trial = fbn_pkg::REM_W'({prev.root, 2'b01});
         sq_in[j] = prev;
         sq_in[j].s = {prev.s[fbn_pkg::SUM_W-3:0], 2'b00};
         if (rem_t >= trial) begin
            sq_in[j].rem = rem_t - trial;
            sq_in[j].root = {prev.root[fbn_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            sq_in[j].rem = rem_t;
            sq_in[j].root = {prev.root[fbn_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   // rounded dividends
   always_comb begin
      sq_type last;
      last = sq_ff[fbn_pkg::SQ_STEPS-1];
      g_in.len = (last.root == '0) ? fbn_pkg::ROOT_W'(1) : last.root;
      for (int k = 0; k < 3; k++) begin
         g_in.rem[k] = (fbn_pkg::DIV_W'(last.mag[k]) << fbn_pkg::FRAC_BITS)
                     + fbn_pkg::DIV_W'(g_in.len >> 1);
      end
      g_in.q = '0;
      g_in.neg = last.neg;
      g_in.zero = last.zero;
   end

   // restoring divide, one quotient bit per stage, all three components in parallel
   always_comb begin
      dv_type prev;
      logic [fbn_pkg::DIV_W-1:0] dsr;
      for (int i = 0; i < fbn_pkg::Q_W; i++) begin
         if (i == 0) begin
            prev = g_ff;
         end else begin
            prev = dv_ff[i-1];
         end
         dsr = fbn_pkg::DIV_W'(prev.len) << (fbn_pkg::Q_W - 1 - i);
         dv_in[i] = prev;
         for (int k = 0; k < 3; k++) begin
            if (prev.rem[k] >= dsr) begin
               dv_in[i].rem[k] = prev.rem[k] - dsr;
               dv_in[i].q[k][fbn_pkg::Q_W-1-i] = 1'b1;
            end
         end
      end
   end

   // clamp, restore sign, and force all axes to zero for a zero vector
   always_comb begin
      logic [fbn_pkg::Q_W-1:0] sat;
      dv_type fin;
      fin = dv_ff[fbn_pkg::Q_W-1];
      for (int k = 0; k < 3; k++) begin
         sat = (fin.q[k] > fbn_pkg::Q_W'(fbn_pkg::AXIS_MAX)) ?
               fbn_pkg::Q_W'(fbn_pkg::AXIS_MAX) : fin.q[k];
         if (fin.zero) begin
            h_in[k] = '0;
         end else if (fin.neg[k]) begin
            h_in[k] = -fbn_pkg::AXIS_W'(sat);
         end else begin
            h_in[k] = fbn_pkg::AXIS_W'(sat);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < fbn_pkg::SQ_STEPS; j++) begin
            sq_ff[j] <= sq_in[j];
         end
         g_ff <= g_in;
         for (int i = 0; i < fbn_pkg::Q_W; i++) begin
            dv_ff[i] <= dv_in[i];
         end
         for (int k = 0; k < 3; k++) begin
            h_ff[k] <= h_in[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         axis[k] = h_ff[k];
      end
   end

endmodule

@@ src/frame_basis_from_normal_up.sv @@
// frame from a normal and an up hint (look-at basis)
//
// req channel: one word per frame setup, tdata packs normal x/y/z, up x/y/z,
// offset x/y/z, 24-bit signed q8.16 each, normal_x in the low bits
// rsp channel: one word per request with the unit side axis and rise axis
// (18-bit signed q2.16), the normal passed through as depth axis and the
// offset passed through as translation
//
// the datapath is a fixed pipeline of three normalize units (abs, prescale,
// square sum, bit-serial square root over 31 stages, restoring divide over
// 17 stages) with two registered cross products in between
// throughput: one word per cycle, the pipeline takes a word every cycle it is not stalled
//
// reset clears every valid bit; no result comes out until new words go in
// when the receiver stalls, the output register holds its word and the
// pipeline keeps moving as long as its last stage is empty, so bubbles are
// squeezed out; once a finished word reaches the last stage the whole
// pipeline and req_tready stall until the output register frees up
module frame_basis_from_normal_up (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // normal_x, normal_y, normal_z, up_x, up_y, up_z, offset_x, offset_y, offset_z
   input  logic [fbn_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // side_axis_x, side_axis_y, side_axis_z, rise_axis_x, rise_axis_y, rise_axis_z,
   // depth_axis_x, depth_axis_y, depth_axis_z, shift_x, shift_y, shift_z, zero pad
   output logic [fbn_pkg::RSP_W-1:0]  rsp_tdata
);

   typedef struct packed {
      fbn_pkg::in_type   [2:0] nrm;
      fbn_pkg::in_type   [2:0] ofs;
      fbn_pkg::axis_type [2:0] side;
   } chain_type;

   // payload carried alongside the normalize units
   chain_type chain_ff [fbn_pkg::DEPTH];
   chain_type chain_in;
   logic [fbn_pkg::DEPTH-1:0] vld_ff;

   fbn_pkg::vec_type  up_vec [3];
   fbn_pkg::axis_type upn [3];
   fbn_pkg::axis_type side [3];
   fbn_pkg::axis_type rise [3];

   fbn_pkg::prod_type x1_p_ff [6];
   fbn_pkg::vec_type  x1_d_ff [3];
   fbn_pkg::prod_type x2_p_ff [6];
   fbn_pkg::vec_type  x2_d_ff [3];

   logic                      rsp_tvalid_ff;
   logic [fbn_pkg::RSP_W-1:0] rsp_tdata_ff;
   logic [fbn_pkg::RSP_W-1:0] rsp_tdata_in;
   logic out_free;
   logic adv;

   function automatic fbn_pkg::prod_type mul(fbn_pkg::in_type n, fbn_pkg::axis_type s);
      fbn_pkg::prod_type p;
      p = fbn_pkg::PROD_W'(n) * fbn_pkg::PROD_W'(s);
      return p;
   endfunction

   // output register free, or last stage empty: the pipe may move
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign adv = out_free || !vld_ff[fbn_pkg::LAST_TAP];
   assign req_tready = adv;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         chain_in.nrm[k] = req_tdata[k*fbn_pkg::IN_W +: fbn_pkg::IN_W];
         chain_in.ofs[k] = req_tdata[(6+k)*fbn_pkg::IN_W +: fbn_pkg::IN_W];
         up_vec[k] = fbn_pkg::vec_type'(
                     $signed(req_tdata[(3+k)*fbn_pkg::IN_W +: fbn_pkg::IN_W]));
      end
      chain_in.side = '0;
   end

   fbn_unit_vec u_up (.clock(clock), .enable(adv), .vec(up_vec), .axis(upn));
   fbn_unit_vec u_side (.clock(clock), .enable(adv), .vec(x1_d_ff), .axis(side));
   fbn_unit_vec u_rise (.clock(clock), .enable(adv), .vec(x2_d_ff), .axis(rise));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[fbn_pkg::DEPTH-2:0], req_tvalid};
      end
   end

   // the side axis joins the payload at its own stage
   always_ff @(posedge clock) begin
      if (adv) begin
         chain_ff[0] <= chain_in;
         for (int p = 1; p < fbn_pkg::DEPTH; p++) begin
            if (p == fbn_pkg::SIDE_TAP) begin
               chain_ff[p].nrm <= chain_ff[p-1].nrm;
               chain_ff[p].ofs <= chain_ff[p-1].ofs;
            end else begin
               chain_ff[p] <= chain_ff[p-1];
            end
         end
         for (int k = 0; k < 3; k++) begin
            chain_ff[fbn_pkg::SIDE_TAP].side[k] <= side[k];
         end
      end
   end

   // side = normalized up cross normal: products, then differences
   always_ff @(posedge clock) begin
      if (adv) begin
         x1_p_ff[0] <= mul(chain_ff[fbn_pkg::U1_TAP].nrm[2], upn[1]);
         x1_p_ff[1] <= mul(chain_ff[fbn_pkg::U1_TAP].nrm[1], upn[2]);
         x1_p_ff[2] <= mul(chain_ff[fbn_pkg::U1_TAP].nrm[0], upn[2]);
         x1_p_ff[3] <= mul(chain_ff[fbn_pkg::U1_TAP].nrm[2], upn[0]);
         x1_p_ff[4] <= mul(chain_ff[fbn_pkg::U1_TAP].nrm[1], upn[0]);
         x1_p_ff[5] <= mul(chain_ff[fbn_pkg::U1_TAP].nrm[0], upn[1]);
         for (int k = 0; k < 3; k++) begin
            x1_d_ff[k] <= fbn_pkg::VEC_W'(x1_p_ff[2*k]) - fbn_pkg::VEC_W'(x1_p_ff[2*k+1]);
         end
      end
   end

   // rise = normal cross side
   always_ff @(posedge clock) begin
      if (adv) begin
         x2_p_ff[0] <= mul(chain_ff[fbn_pkg::U2_TAP].nrm[1], side[2]);
         x2_p_ff[1] <= mul(chain_ff[fbn_pkg::U2_TAP].nrm[2], side[1]);
         x2_p_ff[2] <= mul(chain_ff[fbn_pkg::U2_TAP].nrm[2], side[0]);
         x2_p_ff[3] <= mul(chain_ff[fbn_pkg::U2_TAP].nrm[0], side[2]);
         x2_p_ff[4] <= mul(chain_ff[fbn_pkg::U2_TAP].nrm[0], side[1]);
         x2_p_ff[5] <= mul(chain_ff[fbn_pkg::U2_TAP].nrm[1], side[0]);
         for (int k = 0; k < 3; k++) begin
            x2_d_ff[k] <= fbn_pkg::VEC_W'(x2_p_ff[2*k]) - fbn_pkg::VEC_W'(x2_p_ff[2*k+1]);
         end
      end
   end

   // output word packing
   always_comb begin
      rsp_tdata_in = '0;
      for (int k = 0; k < 3; k++) begin
         rsp_tdata_in[k*fbn_pkg::AXIS_W +: fbn_pkg::AXIS_W] =
            chain_ff[fbn_pkg::LAST_TAP].side[k];
         rsp_tdata_in[(3+k)*fbn_pkg::AXIS_W +: fbn_pkg::AXIS_W] = rise[k];
         rsp_tdata_in[6*fbn_pkg::AXIS_W + k*fbn_pkg::IN_W +: fbn_pkg::IN_W] =
            chain_ff[fbn_pkg::LAST_TAP].nrm[k];
         rsp_tdata_in[6*fbn_pkg::AXIS_W + (3+k)*fbn_pkg::IN_W +: fbn_pkg::IN_W] =
            chain_ff[fbn_pkg::LAST_TAP].ofs[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_tvalid_ff <= vld_ff[fbn_pkg::LAST_TAP];
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

endmodule

@@ src/fbn_checker.sv @@
`include "assert_macros.svh"

module fbn_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [fbn_pkg::RSP_W-1:0] rsp_tdata
);

   fbn_pkg::axis_type side_x;
   fbn_pkg::axis_type rise_x;
   logic              axis_ok;

   assign side_x = rsp_tdata[fbn_pkg::AXIS_W-1:0];
   assign rise_x = rsp_tdata[4*fbn_pkg::AXIS_W-1:3*fbn_pkg::AXIS_W];
   assign axis_ok = (side_x <= fbn_pkg::AXIS_MAX) && (rise_x >= -fbn_pkg::AXIS_MAX);

   // a stalled word stays offered and unchanged
   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // nothing comes out right after reset
   `ASSERT_NEXT_ALWAYS(a_reset_idle, reset, !rsp_tvalid)
   // side axis x stays at or below one, rise axis x at or above minus one
   `ASSERT_NOW(a_axis_range, rsp_tvalid, axis_ok)
   // pad bits above the last field are zero
   `ASSERT_NOW(a_pad_zero, rsp_tvalid, rsp_tdata[fbn_pkg::RSP_W-1:fbn_pkg::RSP_BITS] == '0)

endmodule

bind frame_basis_from_normal_up fbn_checker u_fbn_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

@@ dv/frame_basis_from_normal_up_tb.sv @@
`timescale 1ns / 1ps

module frame_basis_from_normal_up_tb;

   typedef longint vec3_type[3];

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   // normal_x, normal_y, normal_z, up_x, up_y, up_z, offset_x, offset_y, offset_z
   logic [fbn_pkg::REQ_W-1:0]   req_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   // side_axis_x/y/z, rise_axis_x/y/z, depth_axis_x/y/z, shift_x/y/z, zero pad
   logic [fbn_pkg::RSP_W-1:0]   rsp_tdata;

   // frames predicted at the input, waiting for their response word
   logic [fbn_pkg::RSP_W-1:0]   frame_q[$];
   int                 mismatch_count = 0;
   bit                 no_gaps = 0;        // sender and receiver run without idling
   bit                 long_hold = 0;      // receiver stalls for a long stretch once

   frame_basis_from_normal_up DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // integer square root, floor
   function automatic longint unsigned int_root(input longint unsigned s);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s = s - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // scale a vector to unit length in q.FRAC_BITS, zero vectors stay zero
   function automatic vec3_type unit_dir(input vec3_type v);
      vec3_type o;
      longint unsigned mag[3];
      longint unsigned maxm, total, len, q;
      int sh;
      maxm = 0;
      total = 0;
      sh = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (v[i] < 0) ? -v[i] : v[i];
         if (mag[i] > maxm) maxm = mag[i];
      end
      if (maxm == 0) begin
         o[0] = 0; o[1] = 0; o[2] = 0;
         return o;
      end
      // prescale so that every magnitude is below 2^30
      while ((maxm >> sh) >= (64'd1 << 30)) sh++;
      for (int i = 0; i < 3; i++) begin
         mag[i] = mag[i] >> sh;
         total += mag[i] * mag[i];
      end
      len = int_root(total);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << fbn_pkg::FRAC_BITS) + (len >> 1)) / len;
         if (q > fbn_pkg::AXIS_MAX) q = fbn_pkg::AXIS_MAX;
         o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return o;
   endfunction

   function automatic vec3_type cross_prod(input vec3_type a, input vec3_type b);
      vec3_type o;
      o[0] = a[1] * b[2] - b[1] * a[2];
      o[1] = a[2] * b[0] - b[2] * a[0];
      o[2] = a[0] * b[1] - b[0] * a[1];
      return o;
   endfunction

   // full response word for one request word
   function automatic logic [fbn_pkg::RSP_W-1:0] frame_of(input logic [fbn_pkg::REQ_W-1:0] w);
      vec3_type nrm, up, side, rise;
      logic [fbn_pkg::RSP_W-1:0] r;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         nrm[i] = longint'(fbn_pkg::in_type'(w[i*fbn_pkg::IN_W +: fbn_pkg::IN_W]));
         up[i]  = longint'(fbn_pkg::in_type'(w[(3+i)*fbn_pkg::IN_W +: fbn_pkg::IN_W]));
      end
      side = unit_dir(cross_prod(unit_dir(up), nrm));
      rise = unit_dir(cross_prod(nrm, side));
      for (int i = 0; i < 3; i++) begin
         r[i*fbn_pkg::AXIS_W +: fbn_pkg::AXIS_W]     = side[i][fbn_pkg::AXIS_W-1:0];
         r[(3+i)*fbn_pkg::AXIS_W +: fbn_pkg::AXIS_W] = rise[i][fbn_pkg::AXIS_W-1:0];
         r[6*fbn_pkg::AXIS_W + i*fbn_pkg::IN_W +: fbn_pkg::IN_W] =
            w[i*fbn_pkg::IN_W +: fbn_pkg::IN_W];
         r[6*fbn_pkg::AXIS_W + (3+i)*fbn_pkg::IN_W +: fbn_pkg::IN_W] =
            w[(6+i)*fbn_pkg::IN_W +: fbn_pkg::IN_W];
      end
      return r;
   endfunction

   // offer one word, predict its frame once the block takes it
   task automatic send_word(input logic [fbn_pkg::REQ_W-1:0] w);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      frame_q.push_back(frame_of(w));
   endtask

   function automatic logic [fbn_pkg::REQ_W-1:0] pack(input vec3_type n, input vec3_type u,
                                                       input vec3_type o);
      logic [fbn_pkg::REQ_W-1:0] w;
      for (int i = 0; i < 3; i++) begin
         w[i*fbn_pkg::IN_W +: fbn_pkg::IN_W]     = n[i][fbn_pkg::IN_W-1:0];
         w[(3+i)*fbn_pkg::IN_W +: fbn_pkg::IN_W] = u[i][fbn_pkg::IN_W-1:0];
         w[(6+i)*fbn_pkg::IN_W +: fbn_pkg::IN_W] = o[i][fbn_pkg::IN_W-1:0];
      end
      return w;
   endfunction

   function automatic longint rnd_comp(input int kind);
      case (kind)
         0: return longint'(fbn_pkg::in_type'($urandom()));
         1: return longint'($urandom_range(0, 2048)) - 1024;
         2: return longint'($urandom_range(0, 262144)) - 131072;
         default: return longint'(fbn_pkg::in_type'($urandom_range(0, 1) ? 24'h7fffff
                                                                          : 24'h800000));
      endcase
   endfunction

   task automatic test_extremes;
      vec3_type z, mx, mn, ex, ey, ez, o;
      z = '{0, 0, 0};
      mx = '{8388607, 8388607, 8388607};
      mn = '{-8388608, -8388608, -8388608};
      ex = '{65536, 0, 0};
      ey = '{0, 65536, 0};
      ez = '{0, 0, 65536};
      o = '{8388607, -8388608, 1};
      send_word(pack(ez, ey, o));
      send_word(pack(ey, ex, mn));
      send_word(pack(ex, ez, mx));
      send_word(pack(mx, ey, z));
      send_word(pack(mn, ex, mx));
      send_word(pack(mx, mn, o));
      send_word(pack('{8388607, -8388608, 8388607}, '{-8388608, 8388607, 1}, mn));
      send_word(pack('{1, 0, 0}, '{0, 1, 0}, z));
      send_word(pack('{-1, -1, -1}, '{0, 0, 1}, o));
   endtask

   // zero up hint, zero normal, parallel and antiparallel vectors; the zero cases give zero axes
   task automatic test_degenerate;
      vec3_type z, n;
      z = '{0, 0, 0};
      n = '{12345, -67890, 4000};
      send_word(pack(z, z, z));
      send_word(pack(n, z, n));
      send_word(pack(z, n, n));
      send_word(pack(n, n, z));
      send_word(pack(n, '{-n[0], -n[1], -n[2]}, z));
      send_word(pack(n, '{2*n[0], 2*n[1], 2*n[2]}, z));
      send_word(pack('{8388607, 0, 0}, '{-8388608, 0, 0}, z));
      send_word(pack('{0, 0, 1}, '{0, 0, 8388607}, z));
   endtask

   task automatic test_random(input int count);
      vec3_type n, u, o;
      int kind, shape;
      for (int k = 0; k < count; k++) begin
         if (k % 60 == 0) no_gaps = $urandom_range(0, 2) == 0;
         kind = $urandom_range(0, 3);
         shape = $urandom_range(0, 9);
         for (int i = 0; i < 3; i++) begin
            n[i] = rnd_comp(kind);
            u[i] = rnd_comp($urandom_range(0, 3));
            o[i] = rnd_comp(0);
         end
         // occasional nearly parallel hints and vectors with one component zeroed
         if (shape == 0) u = '{n[0] / 2, n[1] / 2, n[2] / 2 + $urandom_range(0, 3)};
         if (shape == 1) begin
            u[$urandom_range(0, 2)] = 0;
            n[$urandom_range(0, 2)] = 0;
         end
         send_word(pack(n, u, o));
      end
      no_gaps = 0;
   endtask

   // receiver stalls long enough for the pipeline to fill and stop taking words
   task automatic test_backpressure;
      vec3_type n, u, o;
      long_hold = 1;
      no_gaps = 1;
      for (int k = 0; k < 220; k++) begin
         for (int i = 0; i < 3; i++) begin
            n[i] = rnd_comp(0);
            u[i] = rnd_comp(2);
            o[i] = rnd_comp(0);
         end
         send_word(pack(n, u, o));
      end
      no_gaps = 0;
   endtask

   // response side: random stalls, then compare each word field by field
   initial begin
      int stall;
      logic [fbn_pkg::RSP_W-1:0] want, got;
      int off, wid;
      rsp_tready = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (long_hold) begin
            stall = 400;
            long_hold = 0;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = rsp_tdata;
         if (frame_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            mismatch_count++;
         end else begin
            want = frame_q.pop_front();
            for (int f = 0; f < 12; f++) begin
               off = (f < 6) ? f * fbn_pkg::AXIS_W
                             : 6 * fbn_pkg::AXIS_W + (f - 6) * fbn_pkg::IN_W;
               wid = (f < 6) ? fbn_pkg::AXIS_W : fbn_pkg::IN_W;
               if (((want ^ got) >> off) & ((256'd1 << wid) - 1)) begin
                  $display("%0t: field %0d expected %h actual %h", $time, f,
                           (want >> off) & ((256'd1 << wid) - 1),
                           (got >> off) & ((256'd1 << wid) - 1));
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      int drain;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_degenerate();
      test_random(200);
      test_backpressure();
      test_random(30);
      req_tvalid <= 1'b0;
      drain = 0;
      while (frame_q.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (fbn_pkg::DEPTH + 20) @(posedge clock);
      if (mismatch_count == 0 && frame_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
